// ===== hw/rtl/mqts_pkg.sv =====
// ----------------------------------------------------------------------------
// Max queue package
// Shared sizes, command and result codes, and request/response payloads.
// ----------------------------------------------------------------------------
`default_nettype none

package mqts_pkg;

   localparam int DEPTH  = 1024;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int ADDR_W = $clog2(DEPTH);

   localparam logic signed [31:0] EMPTY_ANSWER = 32'sh8000_0001;

   typedef enum logic [1:0] {
      OP_ENQ   = 2'd0,
      OP_DEQ   = 2'd1,
      OP_MAX   = 2'd2,
      OP_EMPTY = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      KIND_DEQ   = 2'd0,
      KIND_MAX   = 2'd1,
      KIND_EMPTY = 2'd2,
      KIND_FULL  = 2'd3
   } kind_type;

   typedef struct packed {
      opcode_type        opcode;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      kind_type           result_kind;
      logic signed [31:0] result_value;
      logic               is_empty;
   } rsp_type;

   // one out-stack entry: value and running maximum of itself and everything below it
   typedef struct packed {
      logic signed [31:0] value;
      logic signed [31:0] prefix_max;
   } entry_type;

endpackage

`default_nettype wire

// ===== hw/rtl/max_queue_two_stacks_top.sv =====
// ----------------------------------------------------------------------------
// Max queue from two stacks
// FIFO of signed 32-bit values with a maximum query, built from an in-stack
// and an out-stack that each keep a running prefix maximum.
// ----------------------------------------------------------------------------
//
//   channel   direction   handshake              payload
//   req       in          req_valid / req_ready  mqts_pkg::req_type
//   rsp       out         rsp_valid / rsp_ready  mqts_pkg::rsp_type
//
// Steps: an enqueue that fits is taken in the idle step and gives no response.
// A full enqueue, an empty query or a dequeue of an empty queue goes straight
// to the emit step; a maximum query or any other dequeue first waits on the
// registered read port of a stack RAM. A dequeue that finds the out-stack
// empty first moves the in-stack over, one entry per cycle through the
// in-stack read port.
// Reset: synchronous, active high; clears both stack counts and the control
// state. RAM contents are not cleared; only entries below a count are read.
// Stalls: the response sits in an output register; the sequencer takes the
// next request while it waits and only holds in its emit step if the
// register is still occupied.
//
`default_nettype none

module max_queue_two_stacks_top (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire mqts_pkg::req_type req_payload,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output mqts_pkg::rsp_type      rsp_payload
);

   import mqts_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_XFER,
      ST_POP_WAIT,
      ST_MAX_WAIT,
      ST_EMIT
   } state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   in_count_ff, in_count_in;
   logic [CNT_W-1:0]   out_count_ff, out_count_in;
   logic               pend_ff, pend_in;
   logic signed [31:0] in_top_max_ff, in_top_max_in;
   logic signed [31:0] xfer_max_ff, xfer_max_in;
   rsp_type            res_ff, res_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_payload_ff, rsp_payload_in;

   logic [CNT_W-1:0]   in_cnt_dec;
   logic [CNT_W-1:0]   out_cnt_dec;
   logic               accept;
   logic               slot_free;

   // stack RAM ports
   logic               in_wr_en;
   logic [31:0]        in_rd_data;
   logic               out_wr_en;
   entry_type          out_wr_data;
   entry_type          out_rd_data;

   // shared compare unit
   logic signed [31:0] cmp_a, cmp_b, cmp_y;
   logic signed [31:0] push_max;

   assign in_cnt_dec  = in_count_ff - CNT_W'(1);
   assign out_cnt_dec = out_count_ff - CNT_W'(1);
   assign req_ready   = (state_ff == ST_IDLE);
   assign accept      = req_valid && req_ready;
   assign slot_free   = !rsp_valid_ff || rsp_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // in-stack holds values only; its top maximum lives in in_top_max_ff
   mqts_ram #(
      .WIDTH (32),
      .DEPTH (DEPTH)
   ) u_in_ram (
      .clock      (clock),
      .wr_en      (in_wr_en),
      .wr_addr    (in_count_ff[ADDR_W-1:0]),
      .wr_data    (req_payload.value),
      .rd_addr    (in_cnt_dec[ADDR_W-1:0]),
      .rd_data_ff (in_rd_data)
   );

   mqts_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (DEPTH)
   ) u_out_ram (
      .clock      (clock),
      .wr_en      (out_wr_en),
      .wr_addr    (out_count_ff[ADDR_W-1:0]),
      .wr_data    (out_wr_data),
      .rd_addr    (out_cnt_dec[ADDR_W-1:0]),
      .rd_data_ff (out_rd_data)
   );

   mqts_max_unit u_max (
      .a (cmp_a),
      .b (cmp_b),
      .y (cmp_y)
   );

   // steer the compare unit by step
   always_comb begin
      case (state_ff)
         ST_XFER: begin
            cmp_a = in_rd_data;
            cmp_b = xfer_max_ff;
         end
         ST_MAX_WAIT: begin
            cmp_a = in_top_max_ff;
            cmp_b = out_rd_data.prefix_max;
         end
         default: begin
            cmp_a = req_payload.value;
            cmp_b = in_top_max_ff;
         end
      endcase
   end

   // prefix maximum for the entry moving onto the out-stack
   assign push_max = (out_count_ff == '0) ? in_rd_data : cmp_y;

   always_comb begin
      state_in       = state_ff;
      in_count_in    = in_count_ff;
      out_count_in   = out_count_ff;
      pend_in        = pend_ff;
      in_top_max_in  = in_top_max_ff;
      xfer_max_in    = xfer_max_ff;
      res_in         = res_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_payload_in = rsp_payload_ff;
      in_wr_en       = 1'b0;
      out_wr_en      = 1'b0;
      out_wr_data    = '{value: in_rd_data, prefix_max: push_max};

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               res_in = '{result_kind: KIND_EMPTY, result_value: '0, is_empty: 1'b0};
               case (req_payload.opcode)
                  OP_ENQ: begin
                     if (in_count_ff == CNT_W'(DEPTH)) begin
                        // drop the value and report full
                        res_in.result_kind = KIND_FULL;
                        state_in           = ST_EMIT;
                     end else begin
                        in_wr_en      = 1'b1;
                        in_count_in   = in_count_ff + CNT_W'(1);
                        in_top_max_in = (in_count_ff == '0) ? req_payload.value : cmp_y;
                     end
                  end
                  OP_DEQ: begin
                     res_in.result_kind = KIND_DEQ;
                     if (out_count_ff != '0) begin
                        // top read is already issued; pop it
                        out_count_in = out_cnt_dec;
                        state_in     = ST_POP_WAIT;
                     end else if (in_count_ff != '0) begin
                        // first in-stack read is issued this cycle
                        in_count_in = in_cnt_dec;
                        pend_in     = 1'b1;
                        state_in    = ST_XFER;
                     end else begin
                        res_in.result_value = EMPTY_ANSWER;
                        state_in            = ST_EMIT;
                     end
                  end
                  OP_MAX: begin
                     res_in.result_kind = KIND_MAX;
                     state_in           = ST_MAX_WAIT;
                  end
                  OP_EMPTY: begin
                     res_in.is_empty = (in_count_ff == '0) && (out_count_ff == '0);
                     state_in        = ST_EMIT;
                  end
                  default: begin
                     state_in = ST_EMIT;
                  end
               endcase
            end
         end

         ST_XFER: begin
            // write the entry read last cycle, issue the next read
            if (pend_ff) begin
               out_wr_en    = 1'b1;
               out_count_in = out_count_ff + CNT_W'(1);
               xfer_max_in  = push_max;
            end
            if (in_count_ff != '0) begin
               in_count_in = in_cnt_dec;
               pend_in     = 1'b1;
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  // out-stack filled; its top read is issued now
                  out_count_in = out_cnt_dec;
                  state_in     = ST_POP_WAIT;
               end
            end
         end

         ST_POP_WAIT: begin
            res_in.result_value = out_rd_data.value;
            state_in            = ST_EMIT;
         end

         ST_MAX_WAIT: begin
            if ((in_count_ff != '0) && (out_count_ff != '0)) begin
               res_in.result_value = cmp_y;
            end else if (in_count_ff != '0) begin
               res_in.result_value = in_top_max_ff;
            end else if (out_count_ff != '0) begin
               res_in.result_value = out_rd_data.prefix_max;
            end else begin
               res_in.result_value = EMPTY_ANSWER;
            end
            state_in = ST_EMIT;
         end

         ST_EMIT: begin
            // hold until the response register frees up
            if (slot_free) begin
               rsp_valid_in   = 1'b1;
               rsp_payload_in = res_ff;
               state_in       = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         in_count_ff  <= '0;
         out_count_ff <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         in_count_ff  <= in_count_in;
         out_count_ff <= out_count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      in_top_max_ff  <= in_top_max_in;
      xfer_max_ff    <= xfer_max_in;
      res_ff         <= res_in;
      rsp_payload_ff <= rsp_payload_in;
   end

endmodule

`default_nettype wire

// ===== hw/rtl/mqts_ram.sv =====
// ----------------------------------------------------------------------------
// Max queue stack RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mqts_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data_ff
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// ===== hw/rtl/mqts_max_unit.sv =====
// ----------------------------------------------------------------------------
// Max queue compare unit
// Signed 32-bit maximum shared by push, transfer and query steps.
// ----------------------------------------------------------------------------
`default_nettype none

module mqts_max_unit (
   input  wire logic signed [31:0] a,
   input  wire logic signed [31:0] b,
   output logic signed [31:0]      y
);

   assign y = (a > b) ? a : b;

endmodule

`default_nettype wire
